// File: hdl/sqvt_pkg.sv
package sqvt_pkg;

  // Default quarter-wave table resolution: 2^10 + 1 entries.
  localparam int SINE_TABLE_BITS_DEF = 10;

  // Sine magnitude is Q1.14 in 0..16384; the signed value needs one more bit.
  localparam int SIN_MAG_W = 15;
  localparam int SIN_W     = 16;

  // Scaled sprite size (12-bit texels times Q8.8 scale), Q.8.
  localparam int SIZE_W = 28;

  // Rotated offsets and centre, Q.23.
  localparam int PROD_W = 44;

  // Vertex sum before rounding, Q.23, with headroom for three terms.
  localparam int VSUM_W = 46;

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  // One draw layer step in Q.8 pixels (10000 pixels).
  localparam logic [21:0] DEPTH_STEP_Q8 = 22'd2560000;

  localparam logic [1:0] LAST_CORNER = 2'd3;

  // Per-sprite geometry handed from the setup pipeline to the vertex generator.
  typedef struct packed {
    logic signed [PROD_W-1:0] cx;
    logic signed [PROD_W-1:0] cy;
    logic signed [PROD_W-1:0] swc;
    logic signed [PROD_W-1:0] sws;
    logic signed [PROD_W-1:0] shc;
    logic signed [PROD_W-1:0] shs;
    logic [12:0]              u0;
    logic [12:0]              u1;
    logic [12:0]              v0;
    logic [12:0]              v1;
    logic [31:0]              rgba;
    logic [7:0]               tex_id;
    logic [7:0]               layer;
    logic signed [31:0]       depth;
  } sqvt_geom_t;

  // Two multiply-and-scale steps of the Taylor series, Q.30.
  function automatic longint unsigned taylor_sq(input longint unsigned t,
                                                input longint unsigned x);
    longint unsigned p;
    p = (t * x) >> 30;
    p = (p * x) >> 30;
    return p;
  endfunction

  // Quarter-wave sine entry i of a table with 2^bits steps, Q1.14.
  // Only evaluated at elaboration to build the table.
  function automatic logic [SIN_MAG_W-1:0] sine_entry(input longint unsigned i,
                                                       input int bits);
    longint unsigned n;
    longint unsigned ii;
    longint unsigned x;
    longint unsigned t;
    longint          sum;
    n  = 64'd1 << bits;
    ii = (i > n) ? n : i;
    x  = (PI_HALF_Q30 * ii) >> bits;
    t  = x;
    sum = longint'(x);
    t = taylor_sq(t, x) / 64'd6;   sum = sum - longint'(t);
    t = taylor_sq(t, x) / 64'd20;  sum = sum + longint'(t);
    t = taylor_sq(t, x) / 64'd42;  sum = sum - longint'(t);
    t = taylor_sq(t, x) / 64'd72;  sum = sum + longint'(t);
    t = taylor_sq(t, x) / 64'd110; sum = sum - longint'(t);
    t = taylor_sq(t, x) / 64'd156; sum = sum + longint'(t);
    t = taylor_sq(t, x) / 64'd210; sum = sum - longint'(t);
    if (sum < 0) sum = 0;
    sum = (sum + 64'sd32768) >>> 16;
    if (sum > 64'sd16384) sum = 64'sd16384;
    return sum[SIN_MAG_W-1:0];
  endfunction

endpackage

// File: hdl/sqvt_sine_rom.sv
module sqvt_sine_rom import sqvt_pkg::*; #(
  parameter int TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [15:0]             angle,
  output logic signed [SIN_W-1:0] sin_val,
  output logic signed [SIN_W-1:0] cos_val
);

  localparam int N = 1 << TABLE_BITS;
  localparam logic [TABLE_BITS:0] FULL = {1'b1, {TABLE_BITS{1'b0}}};

  typedef logic [SIN_MAG_W-1:0] rom_t [0:N];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i <= N; i++) begin
      r[i] = sine_entry(64'(i), TABLE_BITS);
    end
    return r;
  endfunction

  localparam rom_t SINE = build_rom();

  logic [1:0]              quad;
  logic [TABLE_BITS-1:0]   idx;
  logic [TABLE_BITS:0]     fwd;
  logic [TABLE_BITS:0]     rev;
  logic [TABLE_BITS:0]     sin_addr;
  logic [TABLE_BITS:0]     cos_addr;
  logic                    sin_neg;
  logic                    cos_neg;
  logic signed [SIN_W-1:0] sin_mag;
  logic signed [SIN_W-1:0] cos_mag;

  // Odd quadrants read the table backwards. Cosine sits one quadrant ahead.
  assign quad     = angle[15:14];
  assign idx      = angle[13 -: TABLE_BITS];
  assign fwd      = {1'b0, idx};
  assign rev      = FULL - fwd;
  assign sin_addr = quad[0] ? rev : fwd;
  assign cos_addr = quad[0] ? fwd : rev;
  assign sin_neg  = quad[1];
  assign cos_neg  = quad[1] ^ quad[0];
  assign sin_mag  = $signed({1'b0, SINE[sin_addr]});
  assign cos_mag  = $signed({1'b0, SINE[cos_addr]});

  always_ff @(posedge clk) begin
    if (en) begin
      sin_val <= sin_neg ? -sin_mag : sin_mag;
      cos_val <= cos_neg ? -cos_mag : cos_mag;
    end
  end

endmodule

// File: hdl/sqvt_sprite_setup.sv
module sqvt_sprite_setup import sqvt_pkg::*; #(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         tex_id,
  input  logic [11:0]        rect_left,
  input  logic [11:0]        rect_top,
  input  logic [11:0]        rect_width,
  input  logic [11:0]        rect_height,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic [15:0]        scale_x,
  input  logic [15:0]        scale_y,
  input  logic [15:0]        angle,
  input  logic [31:0]        rgba,
  input  logic [7:0]         draw_layer,
  output logic               geom_valid,
  output sqvt_geom_t         geom,
  input  logic               geom_ready
);

  // Stage 1: captured request.
  logic               f1_valid;
  logic [7:0]         f1_tex_id;
  logic [11:0]        f1_left;
  logic [11:0]        f1_top;
  logic [11:0]        f1_w;
  logic [11:0]        f1_h;
  logic signed [23:0] f1_px;
  logic signed [23:0] f1_py;
  logic [15:0]        f1_scx;
  logic [15:0]        f1_scy;
  logic [15:0]        f1_angle;
  logic [31:0]        f1_rgba;
  logic [7:0]         f1_layer;

  // Stage 2: scaled size, depth sum, sine and cosine.
  logic               f2_valid;
  logic [SIZE_W-1:0]  f2_sw;
  logic [SIZE_W-1:0]  f2_sh;
  logic signed [23:0] f2_px;
  logic signed [32:0] f2_depth;
  logic [12:0]        f2_u0;
  logic [12:0]        f2_u1;
  logic [12:0]        f2_v0;
  logic [12:0]        f2_v1;
  logic [31:0]        f2_rgba;
  logic [7:0]         f2_tex_id;
  logic [7:0]         f2_layer;
  logic signed [23:0] f2_py;

  logic signed [SIN_W-1:0] sin_val;
  logic signed [SIN_W-1:0] cos_val;

  // Stage 3 is the geometry register itself.
  logic       f3_valid;
  sqvt_geom_t f3;

  logic f1_ready;
  logic f2_ready;
  logic f3_ready;

  // Nothing is taken while reset is held.
  assign f3_ready = !f3_valid || geom_ready;
  assign f2_ready = !f2_valid || f3_ready;
  assign f1_ready = !f1_valid || f2_ready;
  assign in_stall = !f1_ready || rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (f1_ready) begin
      f1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_ready && in_valid) begin
      f1_tex_id <= tex_id;
      f1_left   <= rect_left;
      f1_top    <= rect_top;
      f1_w      <= rect_width;
      f1_h      <= rect_height;
      f1_px     <= pos_x;
      f1_py     <= pos_y;
      f1_scx    <= scale_x;
      f1_scy    <= scale_y;
      f1_angle  <= angle;
      f1_rgba   <= rgba;
      f1_layer  <= draw_layer;
    end
  end

  logic [SIZE_W-1:0]  sw_next;
  logic [SIZE_W-1:0]  sh_next;
  logic [29:0]        layer_step;
  logic signed [32:0] depth_next;

  assign sw_next    = SIZE_W'(f1_w) * SIZE_W'(f1_scx);
  assign sh_next    = SIZE_W'(f1_h) * SIZE_W'(f1_scy);
  assign layer_step = 30'(f1_layer) * 30'(DEPTH_STEP_Q8);
  assign depth_next = $signed({{9{f1_py[23]}}, f1_py}) + $signed({3'b000, layer_step});

  sqvt_sine_rom #(
    .TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom (
    .clk    (clk),
    .en     (f2_ready),
    .angle  (f1_angle),
    .sin_val(sin_val),
    .cos_val(cos_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else if (f2_ready) begin
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f2_ready && f1_valid) begin
      f2_sw     <= sw_next;
      f2_sh     <= sh_next;
      f2_px     <= f1_px;
      f2_py     <= f1_py;
      f2_depth  <= depth_next;
      f2_u0     <= {1'b0, f1_left};
      f2_u1     <= {1'b0, f1_left} + {1'b0, f1_w};
      f2_v0     <= {1'b0, f1_top};
      f2_v1     <= {1'b0, f1_top} + {1'b0, f1_h};
      f2_rgba   <= f1_rgba;
      f2_tex_id <= f1_tex_id;
      f2_layer  <= f1_layer;
    end
  end

  logic signed [SIZE_W:0]   sw_s;
  logic signed [SIZE_W:0]   sh_s;
  logic signed [PROD_W-1:0] swc_next;
  logic signed [PROD_W-1:0] sws_next;
  logic signed [PROD_W-1:0] shc_next;
  logic signed [PROD_W-1:0] shs_next;
  logic signed [PROD_W-1:0] cx_next;
  logic signed [PROD_W-1:0] cy_next;
  logic signed [31:0]       depth_sat;

  assign sw_s     = $signed({1'b0, f2_sw});
  assign sh_s     = $signed({1'b0, f2_sh});
  assign swc_next = PROD_W'(sw_s) * PROD_W'(cos_val);
  assign sws_next = PROD_W'(sw_s) * PROD_W'(sin_val);
  assign shc_next = PROD_W'(sh_s) * PROD_W'(cos_val);
  assign shs_next = PROD_W'(sh_s) * PROD_W'(sin_val);

  // Centre in Q.23: position plus half the scaled size.
  assign cx_next = $signed({{5{f2_px[23]}}, f2_px, 15'b0}) + $signed({2'b00, f2_sw, 14'b0});
  assign cy_next = $signed({{5{f2_py[23]}}, f2_py, 15'b0}) + $signed({2'b00, f2_sh, 14'b0});

  always_comb begin
    if (f2_depth > 33'sd2147483647) begin
      depth_sat = 32'sh7FFFFFFF;
    end else if (f2_depth < -33'sd2147483648) begin
      depth_sat = 32'sh80000000;
    end else begin
      depth_sat = f2_depth[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f3_valid <= 1'b0;
    end else if (f3_ready) begin
      f3_valid <= f2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f3_ready && f2_valid) begin
      f3.cx     <= cx_next;
      f3.cy     <= cy_next;
      f3.swc    <= swc_next;
      f3.sws    <= sws_next;
      f3.shc    <= shc_next;
      f3.shs    <= shs_next;
      f3.u0     <= f2_u0;
      f3.u1     <= f2_u1;
      f3.v0     <= f2_v0;
      f3.v1     <= f2_v1;
      f3.rgba   <= f2_rgba;
      f3.tex_id <= f2_tex_id;
      f3.layer  <= f2_layer;
      f3.depth  <= depth_sat;
    end
  end

  assign geom_valid = f3_valid;
  assign geom       = f3;

endmodule

// File: hdl/sqvt_vertex_gen.sv
module sqvt_vertex_gen import sqvt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               geom_valid,
  input  sqvt_geom_t         geom,
  output logic               geom_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         corner,
  output logic signed [23:0] vert_x,
  output logic signed [23:0] vert_y,
  output logic [12:0]        tex_u,
  output logic [12:0]        tex_v,
  output logic [31:0]        out_rgba,
  output logic [7:0]         out_tex_id,
  output logic [7:0]         out_layer,
  output logic signed [31:0] depth_key,
  output logic               last
);

  localparam int Q_W = VSUM_W - 15;
  localparam logic signed [VSUM_W-1:0] ROUND_HALF = VSUM_W'(1 << 14);
  localparam logic signed [Q_W-1:0] VMAX = Q_W'(8388607);
  localparam logic signed [Q_W-1:0] VMIN = -Q_W'(8388608);

  function automatic logic signed [VSUM_W-1:0] ext(input logic signed [PROD_W-1:0] v);
    return {{(VSUM_W - PROD_W){v[PROD_W-1]}}, v};
  endfunction

  // Round a Q.23 sum to Q.8 (ties upward) and clamp to the 24-bit range.
  function automatic logic signed [23:0] round_sat(input logic signed [VSUM_W-1:0] v);
    logic signed [VSUM_W-1:0] r;
    logic signed [Q_W-1:0]    q;
    r = v + ROUND_HALF;
    q = r[VSUM_W-1:15];
    if (q > VMAX) begin
      return 24'sh7FFFFF;
    end else if (q < VMIN) begin
      return 24'sh800000;
    end else begin
      return q[23:0];
    end
  endfunction

  // Expansion stage: one sprite, walked through its four corners.
  logic       e_valid;
  logic [1:0] e_cnt;
  sqvt_geom_t e_g;

  // Vertex sum stage.
  logic                     v1_valid;
  logic signed [VSUM_W-1:0] v1_vx;
  logic signed [VSUM_W-1:0] v1_vy;
  logic [1:0]               v1_corner;
  logic [12:0]              v1_u;
  logic [12:0]              v1_v;
  logic [31:0]              v1_rgba;
  logic [7:0]               v1_tex_id;
  logic [7:0]               v1_layer;
  logic signed [31:0]       v1_depth;
  logic                     v1_last;

  logic out_ready;
  logic v1_ready;
  logic e_ready;

  assign out_ready  = !out_valid || !out_stall;
  assign v1_ready   = !v1_valid || out_ready;
  assign e_ready    = !e_valid || (e_cnt == LAST_CORNER && v1_ready);
  assign geom_ready = e_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      e_cnt   <= 2'd0;
    end else if (e_ready) begin
      e_valid <= geom_valid;
      e_cnt   <= 2'd0;
    end else if (e_valid && v1_ready) begin
      e_cnt <= e_cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (e_ready && geom_valid) begin
      e_g <= geom;
    end
  end

  logic                     right;
  logic                     bottom;
  logic signed [VSUM_W-1:0] vx_next;
  logic signed [VSUM_W-1:0] vy_next;

  // Corner offsets are +-half size; the products already carry sin and cos.
  assign right   = e_cnt[0] ^ e_cnt[1];
  assign bottom  = e_cnt[1];
  assign vx_next = ext(e_g.cx)
                 + (right  ? ext(e_g.swc) : -ext(e_g.swc))
                 + (bottom ? -ext(e_g.shs) : ext(e_g.shs));
  assign vy_next = ext(e_g.cy)
                 + (right  ? ext(e_g.sws) : -ext(e_g.sws))
                 + (bottom ? ext(e_g.shc) : -ext(e_g.shc));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1_valid <= 1'b0;
    end else if (v1_ready) begin
      v1_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_ready && e_valid) begin
      v1_vx     <= vx_next;
      v1_vy     <= vy_next;
      v1_corner <= e_cnt;
      v1_u      <= right ? e_g.u1 : e_g.u0;
      v1_v      <= bottom ? e_g.v1 : e_g.v0;
      v1_rgba   <= e_g.rgba;
      v1_tex_id <= e_g.tex_id;
      v1_layer  <= e_g.layer;
      v1_depth  <= e_g.depth;
      v1_last   <= (e_cnt == LAST_CORNER);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= v1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && v1_valid) begin
      corner     <= v1_corner;
      vert_x     <= round_sat(v1_vx);
      vert_y     <= round_sat(v1_vy);
      tex_u      <= v1_u;
      tex_v      <= v1_v;
      out_rgba   <= v1_rgba;
      out_tex_id <= v1_tex_id;
      out_layer  <= v1_layer;
      depth_key  <= v1_depth;
      last       <= v1_last;
    end
  end

endmodule

// File: hdl/sprite_quad_vertex_transform.sv
// Sprite quad vertex transform.
// The input channel (in_valid / in_stall) takes one sprite request per item:
// texture id, source rectangle, Q16.8 position, Q8.8 scale, angle, color and
// layer. The output channel (out_valid / out_stall) gives four vertex items per
// sprite in the order top-left, top-right, bottom-right, bottom-left, with
// last set on the fourth. Each carries the rotated and translated position,
// the texture coordinate, the pass-through fields and the depth sort key.
// A sprite passes the three setup stages, the corner walk, the vertex sum and
// the output register. Throughput is one vertex per cycle while out_stall is
// low; the corner walk in the vertex generator sets it, taking the next sprite
// as the last corner moves on. The setup stages keep taking sprites while the
// generator is busy, up to one sprite in each of its three stages.
// Reset clears all valid bits and the corner counter; the pipeline is empty
// and ready once reset is released. The sine table is a constant ROM and
// needs no fill. When the receiver stalls, the output item holds and the stall
// backs up stage by stage; nothing is dropped or repeated.
module sprite_quad_vertex_transform import sqvt_pkg::*; #(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         tex_id,
  input  logic [11:0]        rect_left,
  input  logic [11:0]        rect_top,
  input  logic [11:0]        rect_width,
  input  logic [11:0]        rect_height,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic [15:0]        scale_x,
  input  logic [15:0]        scale_y,
  input  logic [15:0]        angle,
  input  logic [31:0]        rgba,
  input  logic [7:0]         draw_layer,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         corner,
  output logic signed [23:0] vert_x,
  output logic signed [23:0] vert_y,
  output logic [12:0]        tex_u,
  output logic [12:0]        tex_v,
  output logic [31:0]        out_rgba,
  output logic [7:0]         out_tex_id,
  output logic [7:0]         out_layer,
  output logic signed [31:0] depth_key,
  output logic               last
);

  // Geometry of one sprite, handed from setup to the corner walk.
  logic       geom_valid;
  logic       geom_ready;
  sqvt_geom_t geom;

  // Three stages: capture, size/sine/depth, then the rotation products.
  sqvt_sprite_setup #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_setup (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .tex_id     (tex_id),
    .rect_left  (rect_left),
    .rect_top   (rect_top),
    .rect_width (rect_width),
    .rect_height(rect_height),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .scale_x    (scale_x),
    .scale_y    (scale_y),
    .angle      (angle),
    .rgba       (rgba),
    .draw_layer (draw_layer),
    .geom_valid (geom_valid),
    .geom       (geom),
    .geom_ready (geom_ready)
  );

  // Corner walk, vertex sum, then rounding and saturation into the output
  // register.
  sqvt_vertex_gen u_vertex (
    .clk       (clk),
    .rst       (rst),
    .geom_valid(geom_valid),
    .geom      (geom),
    .geom_ready(geom_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .corner    (corner),
    .vert_x    (vert_x),
    .vert_y    (vert_y),
    .tex_u     (tex_u),
    .tex_v     (tex_v),
    .out_rgba  (out_rgba),
    .out_tex_id(out_tex_id),
    .out_layer (out_layer),
    .depth_key (depth_key),
    .last      (last)
  );

endmodule

// File: verif/tb_sprite_quad_vertex_transform.sv
module tb_sprite_quad_vertex_transform;
  import sqvt_pkg::*;

  // The block under test is built with its default table size, so the
  // predictor builds its own quarter-wave table at the same resolution.
  localparam int TABLE_BITS     = SINE_TABLE_BITS_DEF;
  localparam int TABLE_STEPS    = 1 << TABLE_BITS;
  localparam int RANDOM_SPRITES = 151;
  localparam int MAX_WAIT       = 18;
  // Quiet cycles waited at the end to catch any stray extra vertex.
  localparam int DRAIN_CYCLES   = 16;

  typedef enum logic [1:0] {
    TOP_LEFT,
    TOP_RIGHT,
    BOTTOM_RIGHT,
    BOTTOM_LEFT
  } corner_e;

  // One sprite request, as it is presented on the input channel.
  typedef struct {
    logic [7:0]         tex_id;
    logic [11:0]        left;
    logic [11:0]        top;
    logic [11:0]        width;
    logic [11:0]        height;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic [15:0]        sx;
    logic [15:0]        sy;
    logic [15:0]        angle;
    logic [31:0]        rgba;
    logic [7:0]         layer;
  } sprite_req_t;

  // One vertex, as it is expected on the output channel.
  typedef struct {
    logic [1:0]         corner;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [12:0]        u;
    logic [12:0]        v;
    logic [31:0]        rgba;
    logic [7:0]         tex_id;
    logic [7:0]         layer;
    logic signed [31:0] depth;
    logic               last;
  } quad_vertex_t;

  // All inputs of the block start at known values.
  logic               clk;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [7:0]         tex_id      = '0;
  logic [11:0]        rect_left   = '0;
  logic [11:0]        rect_top    = '0;
  logic [11:0]        rect_width  = '0;
  logic [11:0]        rect_height = '0;
  logic signed [23:0] pos_x       = '0;
  logic signed [23:0] pos_y       = '0;
  logic [15:0]        scale_x     = '0;
  logic [15:0]        scale_y     = '0;
  logic [15:0]        angle       = '0;
  logic [31:0]        rgba        = '0;
  logic [7:0]         draw_layer  = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [1:0]         corner;
  logic signed [23:0] vert_x;
  logic signed [23:0] vert_y;
  logic [12:0]        tex_u;
  logic [12:0]        tex_v;
  logic [31:0]        out_rgba;
  logic [7:0]         out_tex_id;
  logic [7:0]         out_layer;
  logic signed [31:0] depth_key;
  logic               last;

  // Sprites waiting to be offered, and vertices predicted but not yet seen.
  sprite_req_t  sprites_to_send [$];
  quad_vertex_t vertices_due [$];

  longint unsigned quarter_wave [0:TABLE_STEPS];

  sprite_req_t on_wire;
  int          hold_off       = 0;
  int          stall_left     = 0;
  int          sprites_taken  = 0;
  int          vertices_seen  = 0;
  int          failures       = 0;
  int          directed_count = 0;

  sprite_quad_vertex_transform dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Appends one sprite to the end of the send queue.
  function automatic void queue_sprite(input sprite_req_t s);
    sprites_to_send = {sprites_to_send, s};
  endfunction

  // Quarter-wave sine entry in Q1.14, from an eight-term Taylor series
  // evaluated in unsigned Q.30 and rounded half up.
  function automatic longint unsigned quarter_wave_entry(input longint unsigned i);
    longint unsigned x;
    longint unsigned term;
    longint          acc;
    x    = (PI_HALF_Q30 * i) / (64'd1 << TABLE_BITS);
    term = x;
    acc  = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    acc = (acc + 32768) >>> 16;
    if (acc > 16384) acc = 16384;
    return longint'(acc);
  endfunction

  // Signed Q1.14 sine of a 16-bit angle. The top two bits pick the quadrant;
  // odd quadrants read the table backward, the lower half-turn is negated.
  function automatic longint sine_of(input logic [15:0] a);
    int unsigned idx;
    longint      mag;
    idx = int'(a[13:0]) >> (14 - TABLE_BITS);
    if (a[14]) mag = longint'(quarter_wave[TABLE_STEPS - idx]);
    else mag = longint'(quarter_wave[idx]);
    return a[15] ? -mag : mag;
  endfunction

  // Q.23 to Q.8, ties toward +infinity, then clamped to 24-bit signed.
  function automatic logic signed [23:0] q23_to_pixel(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r < -8388608) r = -8388608;
    if (r > 8388607) r = 8388607;
    return r[23:0];
  endfunction

  // Works out the four vertices of one accepted sprite and queues them.
  // The box is scaled, centred, rotated clockwise on screen and placed.
  function automatic void predict_quad_vertices(input sprite_req_t s);
    longint       sw;
    longint       sh;
    longint       sn;
    longint       cs;
    longint       cx;
    longint       cy;
    longint       dep;
    longint       dx;
    longint       dy;
    logic [15:0]  quarter_on;
    logic         right;
    logic         bottom;
    quad_vertex_t v;
    sw         = longint'(s.width) * longint'(s.sx);
    sh         = longint'(s.height) * longint'(s.sy);
    quarter_on = s.angle + 16'h4000;
    sn         = sine_of(s.angle);
    cs         = sine_of(quarter_on);
    cx         = longint'(s.px) * 32768 + sw * 16384;
    cy         = longint'(s.py) * 32768 + sh * 16384;
    dep        = longint'(s.py) + longint'(s.layer) * longint'(DEPTH_STEP_Q8);
    if (dep > 64'sd2147483647) dep = 64'sd2147483647;
    if (dep < -64'sd2147483648) dep = -64'sd2147483648;
    for (int k = 0; k < 4; k++) begin
      right    = (k == TOP_RIGHT) || (k == BOTTOM_RIGHT);
      bottom   = (k == BOTTOM_RIGHT) || (k == BOTTOM_LEFT);
      dx       = right ? sw : -sw;
      dy       = bottom ? sh : -sh;
      v.corner = 2'(k);
      v.x      = q23_to_pixel(cx + dx * cs - dy * sn);
      v.y      = q23_to_pixel(cy + dx * sn + dy * cs);
      v.u      = right ? {1'b0, s.left} + {1'b0, s.width} : {1'b0, s.left};
      v.v      = bottom ? {1'b0, s.top} + {1'b0, s.height} : {1'b0, s.top};
      v.rgba   = s.rgba;
      v.tex_id = s.tex_id;
      v.layer  = s.layer;
      v.depth  = dep[31:0];
      v.last   = (k == BOTTOM_LEFT);
      vertices_due = {vertices_due, v};
    end
  endfunction

  // A typical on-screen sprite: modest rectangle, scale near one, position
  // somewhat around a 2560 by 1440 screen, any angle, a low layer.
  function automatic sprite_req_t screen_sprite();
    sprite_req_t s;
    s.tex_id = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    s.left   = 12'($urandom());
    s.top    = 12'($urandom());
    s.width  = 12'($urandom_range(0, 256));
    s.height = 12'($urandom_range(0, 256));
    s.px     = 24'($urandom_range(0, 2816 * 256) - 256 * 256);
    s.py     = 24'($urandom_range(0, 1696 * 256) - 256 * 256);
    s.sx     = 16'($urandom_range(16'h0040, 16'h0400));
    s.sy     = 16'($urandom_range(16'h0040, 16'h0400));
    s.angle  = 16'($urandom());
    s.rgba   = $urandom();
    s.layer  = 8'($urandom_range(0, 15));
    return s;
  endfunction

  // Wait before the next item on either channel. Some stretches run with no
  // waiting at all; elsewhere short and long waits are mixed.
  function automatic int draw_wait(input int count);
    int pick;
    pick = $urandom_range(0, 9);
    if ((count / 24) % 4 == 2) return 0;
    if (pick < 4) return 0;
    if (pick < 7) return $urandom_range(1, 3);
    return $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic compare_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    if (want !== got) begin
      $error("Field %s mismatch: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endtask

  // Compares the vertex on the output ports with the oldest prediction.
  task automatic check_vertex();
    quad_vertex_t want;
    if (vertices_due.size() == 0) begin
      $error("Vertex for corner %0d arrived with no sprite outstanding", corner);
      failures++;
    end else begin
      want = vertices_due.pop_front();
      compare_field("corner", want.corner, corner);
      compare_field("vert_x", want.x, vert_x);
      compare_field("vert_y", want.y, vert_y);
      compare_field("tex_u", want.u, tex_u);
      compare_field("tex_v", want.v, tex_v);
      compare_field("out_rgba", want.rgba, out_rgba);
      compare_field("out_tex_id", want.tex_id, out_tex_id);
      compare_field("out_layer", want.layer, out_layer);
      compare_field("depth_key", want.depth, depth_key);
      compare_field("last", want.last, last);
    end
  endtask

  // Input side. A sprite is taken at an edge where valid is high and stall is
  // low; its vertices are predicted right then. Once the slot is free, the
  // driver either sits out its drawn wait or puts up the next sprite. Valid
  // gets at most one assignment per edge, so a back-to-back sprite keeps it
  // high without a glitch.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_quad_vertices(on_wire);
        sprites_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (hold_off > 0) begin
          hold_off <= hold_off - 1;
          in_valid <= 1'b0;
        end else if (sprites_to_send.size() > 0) begin
          on_wire = sprites_to_send.pop_front();
          tex_id      <= on_wire.tex_id;
          rect_left   <= on_wire.left;
          rect_top    <= on_wire.top;
          rect_width  <= on_wire.width;
          rect_height <= on_wire.height;
          pos_x       <= on_wire.px;
          pos_y       <= on_wire.py;
          scale_x     <= on_wire.sx;
          scale_y     <= on_wire.sy;
          angle       <= on_wire.angle;
          rgba        <= on_wire.rgba;
          draw_layer  <= on_wire.layer;
          in_valid    <= 1'b1;
          hold_off    <= draw_wait(sprites_taken);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side. Every vertex taken is checked at once. After each one the
  // receiver draws how many cycles to hold stall high before the next, so
  // stalls land on every corner of the quad.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        check_vertex();
        vertices_seen++;
        stall_left = draw_wait(vertices_seen);
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
      end
      out_stall <= (stall_left > 0);
    end
  end

  initial begin
    sprite_req_t s;
    logic [15:0] probe_angles [8];

    for (int i = 0; i <= TABLE_STEPS; i++) begin
      quarter_wave[i] = quarter_wave_entry(64'(i));
    end

    // Directed sprites first. Everything zero collapses the quad onto its
    // centre, and so does an untextured sprite of zero size.
    s = '{default: '0};
    queue_sprite(s);

    // Every field at its top value: saturated vertices and the largest
    // texture coordinates and depth.
    s.tex_id = 8'hFF;
    s.left   = 12'hFFF;
    s.top    = 12'hFFF;
    s.width  = 12'hFFF;
    s.height = 12'hFFF;
    s.px     = 24'sh7FFFFF;
    s.py     = 24'sh7FFFFF;
    s.sx     = 16'hFFFF;
    s.sy     = 16'hFFFF;
    s.angle  = 16'hFFFF;
    s.rgba   = 32'hFFFF_FFFF;
    s.layer  = 8'hFF;
    queue_sprite(s);

    // Most negative position at unit scale with no rotation.
    s = '{default: '0};
    s.px    = 24'sh800000;
    s.py    = 24'sh800000;
    s.sx    = 16'h0100;
    s.sy    = 16'h0100;
    s.width = 12'd16;
    queue_sprite(s);

    // The four right angles, half of one, the last step before a full turn,
    // and the two angles on either side of the fourth table step.
    probe_angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                     16'h2000, 16'hFFFF, 16'h003F, 16'h0040};
    foreach (probe_angles[i]) begin
      s = screen_sprite();
      s.width  = 12'd64;
      s.height = 12'd32;
      s.sx     = 16'h0100;
      s.sy     = 16'h0180;
      s.px     = 24'sd25600;
      s.py     = 24'sd12800;
      s.angle  = probe_angles[i];
      queue_sprite(s);
    end

    // Vertices pushed past the top of the range, then past the bottom.
    s = screen_sprite();
    s.px     = 24'sh7F0000;
    s.py     = 24'sh7F0000;
    s.width  = 12'hFFF;
    s.height = 12'hFFF;
    s.sx     = 16'hFFFF;
    s.sy     = 16'hFFFF;
    s.angle  = 16'h0000;
    queue_sprite(s);
    s.px    = 24'sh800000;
    s.py    = 24'sh800000;
    s.angle = 16'h8000;
    queue_sprite(s);

    // Zero scale on one axis only, then a rectangle of zero height.
    s = screen_sprite();
    s.sx = 16'h0000;
    s.sy = 16'h0200;
    queue_sprite(s);
    s = screen_sprite();
    s.height = 12'd0;
    queue_sprite(s);

    // An untextured sprite still carries texture coordinates.
    s = screen_sprite();
    s.tex_id = 8'd0;
    queue_sprite(s);

    // Largest texture coordinates on an otherwise ordinary sprite.
    s = screen_sprite();
    s.left   = 12'hFFF;
    s.top    = 12'hFFF;
    s.width  = 12'hFFF;
    s.height = 12'hFFF;
    s.sx     = 16'h0001;
    s.sy     = 16'h0001;
    queue_sprite(s);

    // Depth key at both ends of what the fields allow.
    s = screen_sprite();
    s.py    = 24'sh7FFFFF;
    s.layer = 8'hFF;
    queue_sprite(s);
    s.py    = 24'sh800000;
    s.layer = 8'h00;
    queue_sprite(s);

    directed_count = sprites_to_send.size();

    // Random sprites: mostly well-formed screen sprites, some with every
    // field fully random, and some huge sprites near the position limits.
    for (int n = 0; n < RANDOM_SPRITES; n++) begin
      s = screen_sprite();
      case ($urandom_range(0, 9))
        6, 7: begin
          s.tex_id = 8'($urandom());
          s.left   = 12'($urandom());
          s.top    = 12'($urandom());
          s.width  = 12'($urandom());
          s.height = 12'($urandom());
          s.px     = 24'($urandom());
          s.py     = 24'($urandom());
          s.sx     = 16'($urandom());
          s.sy     = 16'($urandom());
          s.layer  = 8'($urandom());
        end
        8, 9: begin
          s.width  = 12'($urandom_range(2048, 4095));
          s.height = 12'($urandom_range(2048, 4095));
          s.sx     = 16'($urandom_range(16'h4000, 16'hFFFF));
          s.sy     = 16'($urandom_range(16'h4000, 16'hFFFF));
          s.px     = $urandom_range(0, 1) ? 24'sh7FFFFF - 24'($urandom_range(0, 65535))
                                          : 24'sh800000 + 24'($urandom_range(0, 65535));
          s.py     = $urandom_range(0, 1) ? 24'sh7FFFFF - 24'($urandom_range(0, 65535))
                                          : 24'sh800000 + 24'($urandom_range(0, 65535));
          s.layer  = 8'($urandom());
        end
        default: begin
        end
      endcase
      queue_sprite(s);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Wait until every sprite has been taken, then until every predicted
    // vertex has come out, then a few quiet cycles for any stray vertex.
    while (sprites_to_send.size() != 0 || in_valid) @(posedge clk);
    while (vertices_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d sprites (%0d directed, %0d random), checked %0d vertices, %0d mismatches",
             sprites_taken, directed_count, sprites_taken - directed_count,
             vertices_seen, failures);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Even with every wait at its longest a correct run ends long before
  // this cut-off, which leaves a wide margin.
  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
